// ===== rtl/hsv_to_rgb_convert_defines.svh =====
// Assertion macros for the HSV to RGB colour converter.
// Used by the top level only; needs a clock named i_clk and a reset named i_rst_n.
`ifndef HSV_TO_RGB_CONVERT_DEFINES_SVH
`define HSV_TO_RGB_CONVERT_DEFINES_SVH

// Same-cycle implication, switched off while reset is held
`define HSVRGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held
`define HSVRGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define HSVRGB_ASSERT_NEXT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hsvrgb_pkg.sv =====
// Shared types, constants and helper functions of the HSV to RGB converter.
// No dependencies; imported by every RTL module of the block.
package hsvrgb_pkg;

    // Full-scale level and its integer form for elaboration-time sums
    localparam logic [7:0] LevelMax    = 8'd255;
    localparam int         LevelMaxInt = 255;
    localparam int         NumSectors  = 6;

    // Sector selector advance: add two, or take four off above four
    localparam logic [2:0] SlotWrapAbove = 3'd4;
    localparam logic [2:0] SlotBack      = 3'd4;
    localparam logic [2:0] SlotFwd       = 3'd2;

    // Level selector codes
    localparam logic [2:0] SelFullA  = 3'd1;
    localparam logic [2:0] SelFullB  = 3'd2;
    localparam logic [2:0] SelFall   = 3'd3;
    localparam logic [2:0] SelFloorA = 3'd4;
    localparam logic [2:0] SelFloorB = 3'd5;
    localparam logic [2:0] SelRise   = 3'd6;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness_value;
    } t_hsv_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_out;

    // Fields carried unchanged down the pipe
    typedef struct packed {
        logic [2:0] sel_r;
        logic [2:0] sel_g;
        logic [2:0] sel_b;
        logic       grey;
        logic [7:0] val;
    } t_carry;

    // Sector split stage output
    typedef struct packed {
        t_carry     carry;
        logic [7:0] rem;
        logic [7:0] sat;
    } t_split;

    // Level stage output: floor level and the two products still to scale
    typedef struct packed {
        t_carry      carry;
        logic [7:0]  floor_lvl;
        logic [15:0] fall_prod;
        logic [15:0] rise_prod;
    } t_lvl;

    // Load enables of the three level stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_lvl_en;

    // Truncating divide by 255 for products up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

    function automatic logic [2:0] next_slot(input logic [2:0] s);
        return (s > SlotWrapAbove) ? (s - SlotBack) : (s + SlotFwd);
    endfunction

endpackage

// ===== rtl/hsvrgb_split.sv =====
// Stage 1: scales the hue by six, splits it into sector and remainder,
// and works out the three channel selectors. Depends on hsvrgb_pkg.
module hsvrgb_split (
    input  logic                i_clk,
    input  logic                i_en,
    input  hsvrgb_pkg::t_hsv_in i_data,
    output hsvrgb_pkg::t_split  o_data
);
    import hsvrgb_pkg::*;

    logic [10:0] scaled;
    logic [2:0]  quo;
    logic [10:0] quo_x255;
    logic [2:0]  s_r, s_b, s_g;
    t_split      n_split;
    t_split      r_split;

    // Sector by threshold compares, remainder by subtracting sector * 255
    always_comb begin
        scaled = {1'b0, i_data.hue, 2'b00} + {2'b00, i_data.hue, 1'b0};
        quo    = '0;
        for (int k = 1; k <= NumSectors; k++) begin
            if (scaled >= 11'(k * LevelMaxInt)) begin
                quo = 3'(k);
            end
        end
        quo_x255 = {quo, 8'd0} - {8'd0, quo};
        s_r      = next_slot(quo);
        s_b      = next_slot(s_r);
        s_g      = next_slot(s_b);

        n_split.carry.sel_r = s_r;
        n_split.carry.sel_g = s_g;
        n_split.carry.sel_b = s_b;
        n_split.carry.grey  = (i_data.saturation == '0);
        n_split.carry.val   = i_data.brightness_value;
        n_split.rem         = 8'(scaled - quo_x255);
        n_split.sat         = i_data.saturation;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_split <= n_split;
        end
    end

    assign o_data = r_split;

endmodule

// ===== rtl/hsvrgb_levels.sv =====
// Stages 2 to 4: saturation products, scaling by 1/255, and the products
// with value that give the falling and rising levels. Depends on hsvrgb_pkg.
module hsvrgb_levels (
    input  logic                i_clk,
    input  hsvrgb_pkg::t_lvl_en i_en,
    input  hsvrgb_pkg::t_split  i_data,
    output hsvrgb_pkg::t_lvl    o_data
);
    import hsvrgb_pkg::*;

    // Stage 2 registers
    t_carry      r_c2;
    logic [15:0] r_p_fall, r_p_rise, r_p_floor;
    // Stage 3 registers
    t_carry      r_c3;
    logic [7:0]  r_a_fall, r_a_rise, r_floor3;
    // Stage 4 registers
    t_lvl        r_lvl;

    logic [15:0] n_p_fall, n_p_rise, n_p_floor;
    logic [7:0]  n_a_fall, n_a_rise, n_floor3;
    t_lvl        n_lvl;

    // Stage 2: rem * sat, sat * (255 - rem), val * (255 - sat)
    always_comb begin
        n_p_fall  = i_data.rem * i_data.sat;
        n_p_rise  = i_data.sat * (LevelMax - i_data.rem);
        n_p_floor = i_data.carry.val * (LevelMax - i_data.sat);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_c2      <= i_data.carry;
            r_p_fall  <= n_p_fall;
            r_p_rise  <= n_p_rise;
            r_p_floor <= n_p_floor;
        end
    end

    // Stage 3: scale down, and take the fall and rise terms from full scale
    always_comb begin
        n_a_fall = LevelMax - div255(r_p_fall);
        n_a_rise = LevelMax - div255(r_p_rise);
        n_floor3 = div255(r_p_floor);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_c3     <= r_c2;
            r_a_fall <= n_a_fall;
            r_a_rise <= n_a_rise;
            r_floor3 <= n_floor3;
        end
    end

    // Stage 4: products with value
    always_comb begin
        n_lvl.carry     = r_c3;
        n_lvl.floor_lvl = r_floor3;
        n_lvl.fall_prod = r_c3.val * r_a_fall;
        n_lvl.rise_prod = r_a_rise * r_c3.val;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_lvl <= n_lvl;
        end
    end

    assign o_data = r_lvl;

endmodule

// ===== rtl/hsv_to_rgb_convert.sv =====
// Top level of the HSV to RGB converter: pipeline control, final scaling,
// channel selection and output register. Depends on hsvrgb_pkg and the two stage modules.
//
//  channel   handshake                         payload
//  input     i_in_valid  / o_in_ready         i_in_data  (t_hsv_in)
//  output    o_out_valid / i_out_ready        o_out_data (t_rgb_out)
//
// Five register stages: a transaction passes from the split stage through the level
// stages to the output register, and one can enter every cycle while the pipe has room.
// Each stage holds while the one after it is full and stalled; empty stages
// still fill, so input is taken while a result waits on the output.
// Reset clears the valid bits only; data registers are not reset.
`include "hsv_to_rgb_convert_defines.svh"

module hsv_to_rgb_convert (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hsvrgb_pkg::t_hsv_in  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hsvrgb_pkg::t_rgb_out o_out_data
);
    import hsvrgb_pkg::*;

    localparam int NumStages = 5;

    logic [NumStages-1:0] r_vld, n_vld;
    logic [NumStages-1:0] en;
    t_split               split_q;
    t_lvl                 lvl_q;
    t_lvl_en              lvl_en;
    t_rgb_out             r_out, n_out;
    logic [7:0]           fall_lvl, rise_lvl;

    // Stage enables: a stage loads when empty or when its contents move on
    always_comb begin
        en[NumStages-1] = !r_vld[NumStages-1] || i_out_ready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NumStages; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NumStages-1];

    hsvrgb_split u_split (
        .i_clk  (i_clk),
        .i_en   (en[0]),
        .i_data (i_in_data),
        .o_data (split_q)
    );

    assign lvl_en.s2 = en[1];
    assign lvl_en.s3 = en[2];
    assign lvl_en.s4 = en[3];

    hsvrgb_levels u_levels (
        .i_clk  (i_clk),
        .i_en   (lvl_en),
        .i_data (split_q),
        .o_data (lvl_q)
    );

    function automatic logic [7:0] pick(input logic [2:0] sel, input logic [7:0] full,
                                        input logic [7:0] fall, input logic [7:0] flr,
                                        input logic [7:0] rise);
        logic [7:0] res;
        unique case (sel)
            SelFullA, SelFullB:   res = full;
            SelFall:              res = fall;
            SelFloorA, SelFloorB: res = flr;
            SelRise:              res = rise;
            default:              res = '0;
        endcase
        return res;
    endfunction

    // Stage 5: last scaling, per-channel selection, grey override
    always_comb begin
        fall_lvl = div255(lvl_q.fall_prod);
        rise_lvl = div255(lvl_q.rise_prod);
        if (lvl_q.carry.grey) begin
            n_out.red   = lvl_q.carry.val;
            n_out.green = lvl_q.carry.val;
            n_out.blue  = lvl_q.carry.val;
        end else begin
            n_out.red   = pick(lvl_q.carry.sel_r, lvl_q.carry.val, fall_lvl,
                               lvl_q.floor_lvl, rise_lvl);
            n_out.green = pick(lvl_q.carry.sel_g, lvl_q.carry.val, fall_lvl,
                               lvl_q.floor_lvl, rise_lvl);
            n_out.blue  = pick(lvl_q.carry.sel_b, lvl_q.carry.val, fall_lvl,
                               lvl_q.floor_lvl, rise_lvl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NumStages-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    // Checks
    `HSVRGB_ASSERT_NEXT_RST(a_rst_empty, !i_rst_n, !o_out_valid, "output valid straight after reset")
    `HSVRGB_ASSERT_NOW(a_ready_full, !o_in_ready, r_vld[0] && r_vld[NumStages-1] && !i_out_ready, "input stalled with room in the pipe")
    `HSVRGB_ASSERT_NEXT(a_grey_out, en[NumStages-1] && r_vld[NumStages-2] && lvl_q.carry.grey, (o_out_data.red == o_out_data.green) && (o_out_data.red == o_out_data.blue), "grey transaction gave unequal channels")

endmodule
